@@ hdl/ln_pkg.sv @@
// Shared types and constants for the layer normalization block.
// Used by layer_normalization_top; no dependencies.
package ln_pkg;

    localparam int DATA_W = 16;
    localparam int EPS_W  = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_EPS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AFFINE = 1'd1;

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] scale;
        logic signed [DATA_W-1:0] bias;
        logic                     row_end;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] normalized;
        logic                     final_res;
    } out_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_N2,
        S_N3,
        S_VRD,
        S_VDEV,
        S_VSQ,
        S_VDIV,
        S_ROOT,
        S_DEN,
        S_ORD,
        S_ODEV,
        S_OMUL,
        S_ODIV,
        S_OFIN
    } state_t;

endpackage

@@ hdl/layer_normalization_top.sv @@
// Layer normalization over one buffered row, Q8.8 fixed point.
// Depends on ln_pkg (payload structs, state enum, register indexes).
//
// Usage:
//   in channel : one row element per transfer (sample, scale, bias, row_end).
//                Elements load at one per cycle into the row memory while a
//                running sum is kept. row_end, or filling ROW_MAX entries,
//                closes the row; in_stall then stays high until the row has
//                been emitted.
//   out channel: one normalized element per transfer, in row order, with
//                final_res on the last one. The output register holds a
//                result while out_stall is high; processing pauses there.
//   cfg port   : eps (index 0) and affine_enable (index 1), written when idle.
// After a row closes, the squared deviations are summed, the variance is
// divided out, its square root is taken, and each element is then divided
// and loaded into the output register. D = dividend width of the shared
// restoring divider (one quotient bit per cycle) and R = root width of the
// bit-serial square root (one root bit per cycle); D = 55 and R = 36 for
// ROW_MAX = 64. With no output stall, the divider sets the rate.
// Reset clears the row count and sum, loads eps = 1 and affine_enable = 1,
// and empties the output register. The row memory is not cleared.
module layer_normalization_top #(
    parameter int ROW_MAX = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  ln_pkg::in_t                    in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output ln_pkg::out_t                   out_data,
    input  logic                           cfg_we,
    input  logic [ln_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ln_pkg::EPS_W-1:0]       cfg_data
);

    localparam int DW      = ln_pkg::DATA_W;
    localparam int CNT_W   = $clog2(ROW_MAX + 1);
    localparam int AW      = $clog2(ROW_MAX);
    localparam int SUM_W   = DW + CNT_W;
    localparam int D_W     = SUM_W + 2;
    localparam int A_W     = D_W - 1;
    localparam int SQ_W    = 2 * A_W + CNT_W;
    localparam int V_W     = SQ_W + 1;
    localparam int RAD_W0  = V_W + 16;
    localparam int RAD_W   = RAD_W0 + (RAD_W0 % 2);
    localparam int SD_W    = RAD_W / 2;
    localparam int DEN_W   = SD_W + CNT_W;
    localparam int NUM_W   = A_W + DW + 8;
    localparam int DVS_W   = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 1;
    localparam int DVD_W   = (DVS_W > SQ_W) ? DVS_W : SQ_W;
    localparam int DC_W    = $clog2(DVD_W + 1);
    localparam int SC_W    = $clog2(SD_W + 1);
    localparam int MEM_W   = 3 * DW;
    localparam int Z_W     = DW + 3;

    ln_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [A_W-1:0]          a_reg, a_next;
    logic                    neg_reg, neg_next;
    logic signed [DW-1:0]    scale_reg, scale_next;
    logic signed [DW-1:0]    bias_reg, bias_next;
    logic [SQ_W-1:0]         sumsq_reg, sumsq_next;
    logic [2*CNT_W-1:0]      n2_reg, n2_next;
    logic [DEN_W-1:0]        dvs_reg, dvs_next;
    logic [DVD_W-1:0]        dvd_reg, dvd_next;
    logic [DEN_W:0]          rem_reg, rem_next;
    logic [DC_W-1:0]         dcnt_reg, dcnt_next;
    logic [RAD_W-1:0]        rad_reg, rad_next;
    logic [SD_W+1:0]         srem_reg, srem_next;
    logic [SD_W-1:0]         root_reg, root_next;
    logic [SC_W-1:0]         scnt_reg, scnt_next;
    logic [ln_pkg::EPS_W-1:0] eps_reg;
    logic                    affine_reg;
    ln_pkg::out_t            out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    logic [MEM_W-1:0]        row_mem [ROW_MAX];
    logic [MEM_W-1:0]        rdata_reg;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;

    logic                    in_fire;
    logic                    row_full;
    logic signed [DW-1:0]    rd_sample;
    logic signed [DW-1:0]    rd_scale;
    logic signed [DW-1:0]    rd_bias;
    logic signed [SUM_W:0]   prod_ns;
    logic signed [D_W-1:0]   dev;
    logic [DEN_W:0]          div_trial;
    logic                    div_ge;
    logic [SD_W+2:0]         sq_trial_rem;
    logic [SD_W+2:0]         sq_trial;
    logic                    sq_ge;
    logic [DW-1:0]           abs_scale;
    logic [NUM_W-1:0]        num;
    logic [V_W-1:0]          v_sum;
    logic [DVD_W-1:0]        q_val;
    logic [DW:0]             zq;
    logic signed [Z_W-1:0]   z_val;
    logic signed [DW-1:0]    z_sat;
    logic                    last_elem;

    assign in_stall  = (state_reg != ln_pkg::S_LOAD);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign mem_we    = in_fire;
    assign mem_waddr = cnt_reg[AW-1:0];
    assign row_full  = (cnt_reg == CNT_W'(ROW_MAX - 1));
    assign last_elem = (CNT_W'(idx_reg) == cnt_reg - CNT_W'(1));

    assign rd_sample = rdata_reg[3*DW-1:2*DW];
    assign rd_scale  = rdata_reg[2*DW-1:DW];
    assign rd_bias   = rdata_reg[DW-1:0];
    assign prod_ns   = $signed({1'b0, cnt_reg}) * rd_sample;
    assign dev       = D_W'(prod_ns) - D_W'(sum_reg);

    assign div_trial = {rem_reg[DEN_W-1:0], dvd_reg[DVD_W-1]};
    assign div_ge    = (div_trial >= {1'b0, dvs_reg});

    assign sq_trial_rem = {srem_reg[SD_W:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign sq_trial     = {1'b0, root_reg, 2'b01};
    assign sq_ge        = (sq_trial_rem >= sq_trial);

    assign abs_scale = scale_reg[DW-1] ? DW'(-scale_reg) : DW'(scale_reg);
    assign num = affine_reg ? (NUM_W'(a_reg) * NUM_W'(abs_scale)) << 8
                            : NUM_W'(a_reg) << 16;

    assign v_sum = V_W'(dvd_reg[SQ_W-1:0]) + V_W'(eps_reg);

    assign q_val = (dvs_reg == '0) ? '0 : dvd_reg;
    assign zq    = (|q_val[DVD_W-1:DW]) ? {1'b1, {DW{1'b0}}} : q_val[DW:0];

    always_comb
    begin
        z_val = neg_reg ? -$signed({2'b00, zq}) : $signed({2'b00, zq});
        if (affine_reg)
        begin
            z_val = z_val + Z_W'(bias_reg);
        end
        if (z_val > $signed(Z_W'({1'b0, {(DW-1){1'b1}}})))
        begin
            z_sat = {1'b0, {(DW-1){1'b1}}};
        end
        else if (z_val < -$signed(Z_W'({1'b1, {(DW-1){1'b0}}})))
        begin
            z_sat = {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            z_sat = z_val[DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_waddr] <= {in_data.sample, in_data.scale, in_data.bias};
        end
        rdata_reg <= row_mem[idx_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        a_next         = a_reg;
        neg_next       = neg_reg;
        scale_next     = scale_reg;
        bias_next      = bias_reg;
        sumsq_next     = sumsq_reg;
        n2_next        = n2_reg;
        dvs_next       = dvs_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        rad_next       = rad_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        scnt_next      = scnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ln_pkg::S_LOAD:
            begin
                if (in_fire)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    sum_next = sum_reg + SUM_W'(in_data.sample);
                    if (in_data.row_end || row_full)
                    begin
                        state_next = ln_pkg::S_N2;
                    end
                end
            end
            ln_pkg::S_N2:
            begin
                n2_next    = cnt_reg * cnt_reg;
                state_next = ln_pkg::S_N3;
            end
            ln_pkg::S_N3:
            begin
                dvs_next   = DEN_W'(n2_reg * cnt_reg);
                sumsq_next = '0;
                idx_next   = '0;
                state_next = ln_pkg::S_VRD;
            end
            ln_pkg::S_VRD:
            begin
                state_next = ln_pkg::S_VDEV;
            end
            ln_pkg::S_VDEV:
            begin
                a_next     = dev[D_W-1] ? A_W'(-dev) : A_W'(dev);
                state_next = ln_pkg::S_VSQ;
            end
            ln_pkg::S_VSQ:
            begin
                sumsq_next = sumsq_reg + SQ_W'(a_reg * a_reg);
                if (last_elem)
                begin
                    dvd_next   = DVD_W'(sumsq_reg + SQ_W'(a_reg * a_reg));
                    rem_next   = '0;
                    dcnt_next  = DC_W'(DVD_W);
                    state_next = ln_pkg::S_VDIV;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ln_pkg::S_VRD;
                end
            end
            ln_pkg::S_VDIV:
            begin
                if (dcnt_reg == '0)
                begin
                    rad_next   = RAD_W'({v_sum, 16'h0000});
                    srem_next  = '0;
                    root_next  = '0;
                    scnt_next  = SC_W'(SD_W);
                    state_next = ln_pkg::S_ROOT;
                end
                else
                begin
                    rem_next  = div_ge ? div_trial - {1'b0, dvs_reg} : div_trial;
                    dvd_next  = {dvd_reg[DVD_W-2:0], div_ge};
                    dcnt_next = dcnt_reg - DC_W'(1);
                end
            end
            ln_pkg::S_ROOT:
            begin
                if (scnt_reg == '0)
                begin
                    state_next = ln_pkg::S_DEN;
                end
                else
                begin
                    srem_next = sq_ge ? (SD_W+2)'(sq_trial_rem - sq_trial)
                                      : (SD_W+2)'(sq_trial_rem);
                    root_next = {root_reg[SD_W-2:0], sq_ge};
                    rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                    scnt_next = scnt_reg - SC_W'(1);
                end
            end
            ln_pkg::S_DEN:
            begin
                dvs_next   = DEN_W'(root_reg * cnt_reg);
                idx_next   = '0;
                state_next = ln_pkg::S_ORD;
            end
            ln_pkg::S_ORD:
            begin
                state_next = ln_pkg::S_ODEV;
            end
            ln_pkg::S_ODEV:
            begin
                a_next     = dev[D_W-1] ? A_W'(-dev) : A_W'(dev);
                neg_next   = dev[D_W-1];
                scale_next = rd_scale;
                bias_next  = rd_bias;
                state_next = ln_pkg::S_OMUL;
            end
            ln_pkg::S_OMUL:
            begin
                dvd_next   = DVD_W'(num) + DVD_W'(dvs_reg >> 1);
                neg_next   = neg_reg ^ (affine_reg && scale_reg[DW-1]);
                rem_next   = '0;
                dcnt_next  = DC_W'(DVD_W);
                state_next = ln_pkg::S_ODIV;
            end
            ln_pkg::S_ODIV:
            begin
                if (dcnt_reg == '0)
                begin
                    state_next = ln_pkg::S_OFIN;
                end
                else
                begin
                    rem_next  = div_ge ? div_trial - {1'b0, dvs_reg} : div_trial;
                    dvd_next  = {dvd_reg[DVD_W-2:0], div_ge};
                    dcnt_next = dcnt_reg - DC_W'(1);
                end
            end
            ln_pkg::S_OFIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next       = 1'b1;
                    out_next.normalized  = z_sat;
                    out_next.final_res   = last_elem;
                    if (last_elem)
                    begin
                        cnt_next   = '0;
                        sum_next   = '0;
                        state_next = ln_pkg::S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ln_pkg::S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = ln_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ln_pkg::S_LOAD;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            eps_reg       <= ln_pkg::EPS_RESET;
            affine_reg    <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ln_pkg::REG_EPS:
                    begin
                        eps_reg <= cfg_data;
                    end
                    ln_pkg::REG_AFFINE:
                    begin
                        affine_reg <= cfg_data[0];
                    end
                    default:
                    begin
                        eps_reg <= eps_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        neg_reg   <= neg_next;
        scale_reg <= scale_next;
        bias_reg  <= bias_next;
        sumsq_reg <= sumsq_next;
        n2_reg    <= n2_next;
        dvs_reg   <= dvs_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        dcnt_reg  <= dcnt_next;
        rad_reg   <= rad_next;
        srem_reg  <= srem_next;
        root_reg  <= root_next;
        scnt_reg  <= scnt_next;
        out_reg   <= out_next;
    end

endmodule
